// ===== rtl/pcx_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register indexes and helpers for the PCX run-length clip decoder.
// No dependencies; used by pcx_out_reg and pcx_rle_clip_decoder_unit.
package pcx_pkg;

  localparam int unsigned DIM_W  = 13;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned TOT_W  = 25;
  localparam int unsigned PARA_W = 21;
  localparam int unsigned IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_CLIP_WIDTH   = 2'd2;
  localparam logic [IDX_W-1:0] REG_CLIP_HEIGHT  = 2'd3;

  localparam logic [7:0] RUN_MARK = 8'hc0;

  // One decoded row segment as it leaves the block.
  typedef struct packed {
    logic [7:0]        pixel_value;
    logic [CNT_W-1:0]  kept_pixels;
    logic [DIM_W-1:0]  pad_zeros;
    logic              row_end;
    logic              image_end;
    logic [PARA_W-1:0] paragraphs;
    logic              last;
  } seg_t;

  // Clamp a dimension register to lo..max_dim, lo being 1 or 0.
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic lo_one,
                                                 int unsigned max_dim);
    logic [DIM_W-1:0] res;
    res = v;
    if (lo_one && (v == '0)) res = DIM_W'(1);
    else if ({19'b0, v} > 32'(max_dim)) res = DIM_W'(max_dim);
    return res;
  endfunction

endpackage

// ===== rtl/pcx_rle_clip_decoder_unit.sv =====
`timescale 1ns / 1ps
// Top level of the PCX 8-bit run-length decoder with clip window.
// Depends on pcx_pkg and pcx_out_reg.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------
//  in      | input     | in_valid / in_ready   | in_data_byte
//  out     | output    | out_valid / out_ready | pixel_value, kept_pixels, pad_zeros,
//          |           |                       | row_end, image_end, paragraphs, last
//  cfg     | input     | cfg_we (no wait)      | cfg_index, cfg_data
//
// A run header or a zero-length run gives no word. Every other byte is taken in the
// idle step, then each row segment passes a prepare step and an emit step, set by the
// single segment datapath that the sequencer steps through each segment; the sequencer
// takes no new byte until the last segment of a byte has been emitted.
// in_ready is high only while the sequencer is idle; a finished word may still wait
// in the output register while the next byte is taken.
// A stalled output holds the sequencer in its emit step. Reset is synchronous,
// active low, and restores the register defaults with all position state cleared.
module pcx_rle_clip_decoder_unit #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_data_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_pixel_value,
  output logic [pcx_pkg::CNT_W-1:0]       out_kept_pixels,
  output logic [pcx_pkg::DIM_W-1:0]       out_pad_zeros,
  output logic                            out_row_end,
  output logic                            out_image_end,
  output logic [pcx_pkg::PARA_W-1:0]      out_paragraphs,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [pcx_pkg::IDX_W-1:0]       cfg_index,
  input  logic [pcx_pkg::DIM_W-1:0]       cfg_data
);

  localparam int unsigned DW = pcx_pkg::DIM_W;
  localparam int unsigned CW = pcx_pkg::CNT_W;
  localparam int unsigned TW = pcx_pkg::TOT_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PREP = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state_r;

  // Configuration, stored already clamped.
  logic [DW-1:0] iw_r, ih_r, cw_r, ch_r;

  // Decoder position state.
  logic          awaiting_r;
  logic [CW-1:0] pend_r;
  logic [DW-1:0] column_r;
  logic [DW-1:0] row_r;
  logic [TW-1:0] total_r;

  // Current run and per-segment prepared values.
  logic [7:0]    value_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] room_r;
  logic [DW-1:0] lim_r;
  logic          inwin_r;
  logic [DW-1:0] pad_r;

  // Output register handshake.
  logic          load_valid;
  logic          load_ready;
  pcx_pkg::seg_t load_seg;
  pcx_pkg::seg_t out_seg;

  // Emit-step arithmetic.
  logic          seg_full;
  logic [CW-1:0] seg_len;
  logic [CW-1:0] seg_kept;
  logic [DW-1:0] seg_pad;
  logic [DW:0]   row_inc;
  logic          seg_iend;
  logic [TW-1:0] total_sum;
  logic [CW-1:0] cnt_left;

  assign in_ready = (state_r == S_IDLE);

  // Run fills the rest of the row when the count reaches the room left.
  assign seg_full  = ({{(DW-CW){1'b0}}, cnt_r} >= room_r);
  assign seg_len   = seg_full ? room_r[CW-1:0] : cnt_r;
  assign seg_kept  = !inwin_r ? '0 :
                     (({{(DW-CW){1'b0}}, seg_len} < lim_r) ? seg_len : lim_r[CW-1:0]);
  assign seg_pad   = seg_full ? pad_r : '0;
  assign row_inc   = {1'b0, row_r} + (DW+1)'(1);
  assign seg_iend  = seg_full && (row_inc >= {1'b0, ih_r});
  assign total_sum = total_r + {{(TW-CW){1'b0}}, seg_kept} + {{(TW-DW){1'b0}}, seg_pad};
  // Drop leftover pixels once the image ends.
  assign cnt_left  = seg_iend ? '0 : (cnt_r - seg_len);

  assign load_valid = (state_r == S_EMIT);

  always_comb begin
    load_seg             = '0;
    load_seg.pixel_value = value_r;
    load_seg.kept_pixels = seg_kept;
    load_seg.pad_zeros   = seg_pad;
    load_seg.row_end     = seg_full;
    load_seg.image_end   = seg_iend;
    load_seg.paragraphs  = seg_iend ? total_sum[TW-1:4] : '0;
    load_seg.last        = (cnt_left == '0);
  end

  // Configuration writes; clamp on the way in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r <= pcx_pkg::clamp_dim(DW'(640), 1'b1, MAX_DIM);
      ih_r <= pcx_pkg::clamp_dim(DW'(480), 1'b1, MAX_DIM);
      cw_r <= pcx_pkg::clamp_dim(DW'(320), 1'b0, MAX_DIM);
      ch_r <= pcx_pkg::clamp_dim(DW'(200), 1'b0, MAX_DIM);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcx_pkg::REG_IMAGE_WIDTH:  iw_r <= pcx_pkg::clamp_dim(cfg_data, 1'b1, MAX_DIM);
        pcx_pkg::REG_IMAGE_HEIGHT: ih_r <= pcx_pkg::clamp_dim(cfg_data, 1'b1, MAX_DIM);
        pcx_pkg::REG_CLIP_WIDTH:   cw_r <= pcx_pkg::clamp_dim(cfg_data, 1'b0, MAX_DIM);
        pcx_pkg::REG_CLIP_HEIGHT:  ch_r <= pcx_pkg::clamp_dim(cfg_data, 1'b0, MAX_DIM);
        default: ;
      endcase
    end
  end

  // Sequencer and position state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      awaiting_r <= 1'b0;
      pend_r     <= '0;
      column_r   <= '0;
      row_r      <= '0;
      total_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (awaiting_r) begin
              // Value byte of a run; a zero count yields nothing.
              awaiting_r <= 1'b0;
              pend_r     <= '0;
              if (pend_r != '0) state_r <= S_PREP;
            end else if ((in_data_byte & pcx_pkg::RUN_MARK) == pcx_pkg::RUN_MARK) begin
              awaiting_r <= 1'b1;
              pend_r     <= in_data_byte[CW-1:0];
            end else begin
              state_r <= S_PREP;
            end
          end
        end
        S_PREP: begin
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          // Hold here while the output register is full.
          if (load_ready) begin
            if (seg_full) begin
              column_r <= '0;
              if (seg_iend) begin
                row_r   <= '0;
                total_r <= '0;
              end else begin
                row_r   <= row_inc[DW-1:0];
                total_r <= total_sum;
              end
            end else begin
              column_r <= column_r + {{(DW-CW){1'b0}}, seg_len};
              total_r  <= total_sum;
            end
            state_r <= (cnt_left == '0) ? S_IDLE : S_PREP;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Run payload and prepared segment values.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      value_r <= in_data_byte;
      cnt_r   <= awaiting_r ? pend_r : CW'(1);
    end else if (state_r == S_EMIT && load_ready) begin
      cnt_r <= cnt_left;
    end
    if (state_r == S_PREP) begin
      room_r  <= (column_r < iw_r) ? (iw_r - column_r) : DW'(1);
      lim_r   <= cw_r - column_r;
      inwin_r <= (row_r < ch_r) && (column_r < cw_r);
      pad_r   <= ((row_r < ch_r) && (cw_r > iw_r)) ? (cw_r - iw_r) : '0;
    end
  end

  pcx_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (load_valid),
    .load_ready (load_ready),
    .load_seg   (load_seg),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_seg    (out_seg)
  );

  assign out_pixel_value = out_seg.pixel_value;
  assign out_kept_pixels = out_seg.kept_pixels;
  assign out_pad_zeros   = out_seg.pad_zeros;
  assign out_row_end     = out_seg.row_end;
  assign out_image_end   = out_seg.image_end;
  assign out_paragraphs  = out_seg.paragraphs;
  assign out_last        = out_seg.last;

endmodule

// ===== rtl/pcx_out_reg.sv =====
`timescale 1ns / 1ps
// Output register stage for decoded segments: holds one word until taken.
// Depends on pcx_pkg (seg_t).
module pcx_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load_valid,
  output logic          load_ready,
  input  pcx_pkg::seg_t load_seg,
  output logic          out_valid,
  input  logic          out_ready,
  output pcx_pkg::seg_t out_seg
);

  logic          valid_r;
  pcx_pkg::seg_t seg_r;

  assign load_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_seg    = seg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ready) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      seg_r <= load_seg;
    end
  end

endmodule

// ===== rtl/pcx_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the decoder's output words, bound to the top level.
// Depends on pcx_pkg widths and pcx_rle_clip_decoder_unit ports.
module pcx_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [7:0]                 out_pixel_value,
  input logic [pcx_pkg::DIM_W-1:0]  out_pad_zeros,
  input logic                       out_row_end,
  input logic                       out_image_end,
  input logic [pcx_pkg::PARA_W-1:0] out_paragraphs,
  input logic                       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_value))
    else $error("stalled output word changed");

  a_iend_rend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_end |-> out_row_end)
    else $error("image end without row end");

  a_iend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_end |-> out_last)
    else $error("image end word not last of its byte");

  a_pad_rend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_row_end |-> out_pad_zeros == '0)
    else $error("padding outside row end");

  a_para_iend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_image_end |-> out_paragraphs == '0)
    else $error("paragraph count outside image end");

endmodule

bind pcx_rle_clip_decoder_unit pcx_checker u_pcx_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pixel_value (out_pixel_value),
  .out_pad_zeros   (out_pad_zeros),
  .out_row_end     (out_row_end),
  .out_image_end   (out_image_end),
  .out_paragraphs  (out_paragraphs),
  .out_last        (out_last)
);

// ===== sim/pcx_rle_clip_decoder_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pcx_rle_clip_decoder_unit: directed and random PCX byte
// streams against a cycle-free decoder predictor. Depends on pcx_pkg and the unit RTL.
module pcx_rle_clip_decoder_unit_test;

  localparam int unsigned MAX_DIM        = 4096;
  localparam int unsigned RANDOM_ITEMS   = 240;
  localparam int unsigned SETTLE_CYCLES  = 6;    // header/zero run may still be in flight
  localparam int unsigned TAIL_CYCLES    = 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000; // cycles with no word on either channel
  localparam int unsigned TOTAL_MASK     = 32'h1FF_FFFF;

  typedef enum logic [0:0] {STEP_BYTE, STEP_CFG} kind_t;
  // EXP_PREDICT: take the predictor's words; EXP_NONE / EXP_ONE: expectation spelled out.
  typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_ONE} exp_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_THROTTLE} rx_mode_t;

  typedef struct packed {
    kind_t                     kind;
    logic [pcx_pkg::IDX_W-1:0] reg_idx;
    logic [pcx_pkg::DIM_W-1:0] reg_val;
    logic [7:0]                data;
    exp_t                      how;
    pcx_pkg::seg_t             word;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_pixel_value;
  logic [pcx_pkg::CNT_W-1:0] out_kept_pixels;
  logic [pcx_pkg::DIM_W-1:0] out_pad_zeros;
  logic out_row_end;
  logic out_image_end;
  logic [pcx_pkg::PARA_W-1:0] out_paragraphs;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [pcx_pkg::IDX_W-1:0] cfg_index = pcx_pkg::REG_IMAGE_WIDTH;
  logic [pcx_pkg::DIM_W-1:0] cfg_data = '0;

  pcx_rle_clip_decoder_unit #(.MAX_DIM(MAX_DIM)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel_value(out_pixel_value), .out_kept_pixels(out_kept_pixels),
    .out_pad_zeros(out_pad_zeros), .out_row_end(out_row_end),
    .out_image_end(out_image_end), .out_paragraphs(out_paragraphs), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Decoder state as the predictor tracks it; registers hold the raw written value.
  logic [pcx_pkg::DIM_W-1:0] width_reg  = pcx_pkg::DIM_W'(640);
  logic [pcx_pkg::DIM_W-1:0] height_reg = pcx_pkg::DIM_W'(480);
  logic [pcx_pkg::DIM_W-1:0] clipw_reg  = pcx_pkg::DIM_W'(320);
  logic [pcx_pkg::DIM_W-1:0] cliph_reg  = pcx_pkg::DIM_W'(200);
  bit               run_armed  = 1'b0;
  int unsigned      run_len    = 0;
  int unsigned      col_pos    = 0;
  int unsigned      row_pos    = 0;
  int unsigned      pix_written = 0;

  pcx_pkg::seg_t fresh_segs[$];     // words caused by the byte just taken
  pcx_pkg::seg_t expected_segs[$];  // words still owed by the block, oldest first
  int unsigned errors = 0;
  int unsigned bytes_fed = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Split a run of 'count' pixels into row segments; each completed row may pad, and
  // the image end reports paragraphs, clears position and drops the rest of the run.
  task automatic emit_run(input logic [7:0] value, input int unsigned count);
    int unsigned iw, ih, cw, ch, room, len, kept, pad;
    pcx_pkg::seg_t seg, prev;
    bit   held;
    iw = (width_reg == 0) ? 1 : ((width_reg > MAX_DIM) ? MAX_DIM : width_reg);
    ih = (height_reg == 0) ? 1 : ((height_reg > MAX_DIM) ? MAX_DIM : height_reg);
    cw = (clipw_reg > MAX_DIM) ? MAX_DIM : clipw_reg;
    ch = (cliph_reg > MAX_DIM) ? MAX_DIM : cliph_reg;
    held = 1'b0;
    prev = '0;
    while (count > 0) begin
      // A column left past the row edge by a register change ends the row at once.
      room = (col_pos < iw) ? iw - col_pos : 1;
      len  = (count < room) ? count : room;
      kept = 0;
      pad  = 0;
      seg  = '0;
      seg.pixel_value = value;
      if (row_pos < ch && col_pos < cw) kept = (len < cw - col_pos) ? len : cw - col_pos;
      pix_written = (pix_written + kept) & TOTAL_MASK;
      count   -= len;
      col_pos += len;
      if (len == room) begin
        seg.row_end = 1'b1;
        if (row_pos < ch && cw > iw) pad = cw - iw;
        pix_written = (pix_written + pad) & TOTAL_MASK;
        col_pos = 0;
        row_pos++;
        if (row_pos >= ih) begin
          seg.image_end  = 1'b1;
          seg.paragraphs = pcx_pkg::PARA_W'(pix_written >> 4);
          row_pos     = 0;
          pix_written = 0;
          count       = 0;
        end
      end
      col_pos &= 32'h1FFF;
      row_pos &= 32'h1FFF;
      seg.kept_pixels = pcx_pkg::CNT_W'(kept);
      seg.pad_zeros   = pcx_pkg::DIM_W'(pad);
      if (held) fresh_segs.push_back(prev);
      prev = seg;
      held = 1'b1;
    end
    // Flag the final word of this byte.
    if (held) begin
      prev.last = 1'b1;
      fresh_segs.push_back(prev);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    int unsigned cnt;
    if (run_armed) begin
      cnt       = run_len;
      run_armed = 1'b0;
      run_len   = 0;
      emit_run(b, cnt);
    end else if ((b & pcx_pkg::RUN_MARK) == pcx_pkg::RUN_MARK) begin
      run_len   = b[5:0];
      run_armed = 1'b1;
    end else begin
      emit_run(b, 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Present one byte and hold it until taken. Bursts of random length alternate
  // with random gaps; valid stays high across a burst.
  task automatic send_word(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_data_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // Send a byte, then queue what it must produce: predicted, none, or one typed word.
  task automatic feed(input logic [7:0] b, input exp_t how, input pcx_pkg::seg_t typed);
    send_word(b);
    decode_byte(b);
    case (how)
      EXP_PREDICT: while (fresh_segs.size() != 0) expected_segs.push_back(fresh_segs.pop_front());
      EXP_ONE:     expected_segs.push_back(typed);
      EXP_NONE:    ;
    endcase
    fresh_segs.delete();
    bytes_fed++;
  endtask

  // Drop valid, let every owed word drain and the sequencer settle, then write.
  task automatic write_reg(input logic [pcx_pkg::IDX_W-1:0] idx,
                           input logic [pcx_pkg::DIM_W-1:0] val);
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_segs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      pcx_pkg::REG_IMAGE_WIDTH:  width_reg  = val;
      pcx_pkg::REG_IMAGE_HEIGHT: height_reg = val;
      pcx_pkg::REG_CLIP_WIDTH:   clipw_reg  = val;
      pcx_pkg::REG_CLIP_HEIGHT:  cliph_reg  = val;
    endcase
  endtask

  // Mostly small dimensions; now and then an extreme, clamped or out-of-range value.
  function automatic logic [pcx_pkg::DIM_W-1:0] pick_dim(input int unsigned lo,
                                                         input int unsigned hi);
    if ($urandom_range(0, 7) != 0) return pcx_pkg::DIM_W'($urandom_range(lo, hi));
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return pcx_pkg::DIM_W'(4096);
      2:       return pcx_pkg::DIM_W'(4097);
      default: return '1;
    endcase
  endfunction

  function automatic step_t byte_step(input logic [7:0] d, input exp_t how,
                                      input pcx_pkg::seg_t w);
    return '{STEP_BYTE, pcx_pkg::REG_IMAGE_WIDTH, '0, d, how, w};
  endfunction

  function automatic step_t reg_step(input logic [pcx_pkg::IDX_W-1:0] idx,
                                     input logic [pcx_pkg::DIM_W-1:0] v);
    return '{STEP_CFG, idx, v, 8'h00, EXP_NONE, '0};
  endfunction

  // Word of a run that stays inside a kept row: value, kept count and last flag, nothing else.
  function automatic pcx_pkg::seg_t mid_row_seg(input logic [7:0] v,
                                                input logic [pcx_pkg::CNT_W-1:0] k);
    return '{v, k, '0, 1'b0, 1'b0, '0, 1'b1};
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: stall pattern changes mode at random, each mode held for a random span of cycles
  // ---------------------------------------------------------------------------
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(20, 120);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     out_ready = 1'b1;
      RX_COIN:     out_ready = ($urandom_range(0, 9) < 6);
      RX_THROTTLE: out_ready = (rx_tick % 4 == 0);
      default:     out_ready = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result check: every taken word against the oldest expectation
  // ---------------------------------------------------------------------------
  pcx_pkg::seg_t want_seg;

  task automatic compare_field(input string what, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_segs.size() == 0) begin
        $display("%0t: unexpected word, expected none, got value %0d kept %0d", $time,
                 out_pixel_value, out_kept_pixels);
        errors++;
      end else begin
        want_seg = expected_segs.pop_front();
        compare_field("pixel_value", want_seg.pixel_value, out_pixel_value);
        compare_field("kept_pixels", want_seg.kept_pixels, out_kept_pixels);
        compare_field("pad_zeros", want_seg.pad_zeros, out_pad_zeros);
        compare_field("row_end", want_seg.row_end, out_row_end);
        compare_field("image_end", want_seg.image_end, out_image_end);
        compare_field("paragraphs", want_seg.paragraphs, out_paragraphs);
        compare_field("last", want_seg.last, out_last);
      end
    end
  end

  // Watchdog: end the run when neither channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  step_t plan[$];

  initial begin
    int unsigned random_start, phase_left, pick;
    logic [5:0]  run_cnt;

    // Directed part, from reset defaults (640 x 480, clip 320 x 200).
    plan.push_back(byte_step(8'h00, EXP_ONE, mid_row_seg(8'h00, 6'd1)));
    plan.push_back(byte_step(8'hBF, EXP_ONE, mid_row_seg(8'hBF, 6'd1)));
    // Zero-length run: header and value byte both give nothing.
    plan.push_back(byte_step(8'hC0, EXP_NONE, '0));
    plan.push_back(byte_step(8'h7E, EXP_NONE, '0));
    // Longest run, then a run whose value looks like a header.
    plan.push_back(byte_step(8'hFF, EXP_NONE, '0));
    plan.push_back(byte_step(8'hFF, EXP_ONE, mid_row_seg(8'hFF, 6'd63)));
    plan.push_back(byte_step(8'hC2, EXP_NONE, '0));
    plan.push_back(byte_step(8'hC0, EXP_ONE, mid_row_seg(8'hC0, 6'd2)));
    // Shrink to 5 x 2 with clip 8 x 1: column is now past the row edge.
    plan.push_back(reg_step(pcx_pkg::REG_IMAGE_WIDTH, pcx_pkg::DIM_W'(5)));
    plan.push_back(reg_step(pcx_pkg::REG_IMAGE_HEIGHT, pcx_pkg::DIM_W'(2)));
    plan.push_back(reg_step(pcx_pkg::REG_CLIP_WIDTH, pcx_pkg::DIM_W'(8)));
    plan.push_back(reg_step(pcx_pkg::REG_CLIP_HEIGHT, pcx_pkg::DIM_W'(1)));
    plan.push_back(byte_step(8'h11, EXP_PREDICT, '0));
    // Run past image end (leftover dropped), then a run crossing a row and again past image end.
    plan.push_back(byte_step(8'hC7, EXP_PREDICT, '0));
    plan.push_back(byte_step(8'h2A, EXP_PREDICT, '0));
    plan.push_back(byte_step(8'hCC, EXP_PREDICT, '0));
    plan.push_back(byte_step(8'h05, EXP_PREDICT, '0));
    // Clamping: zero clip, zero width, out-of-range sizes.
    plan.push_back(reg_step(pcx_pkg::REG_CLIP_WIDTH, '0));
    plan.push_back(reg_step(pcx_pkg::REG_IMAGE_WIDTH, '0));
    plan.push_back(byte_step(8'h80, EXP_PREDICT, '0));
    plan.push_back(reg_step(pcx_pkg::REG_IMAGE_WIDTH, '1));
    plan.push_back(reg_step(pcx_pkg::REG_IMAGE_HEIGHT, '0));
    plan.push_back(reg_step(pcx_pkg::REG_CLIP_WIDTH, '1));
    plan.push_back(reg_step(pcx_pkg::REG_CLIP_HEIGHT, '1));
    plan.push_back(byte_step(8'h3C, EXP_PREDICT, '0));

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else feed(plan[i].data, plan[i].how, plan[i].word);
    end

    // Random phases: new sizes each phase (written while idle), then a stream that is
    // mostly well-formed runs and literals, with some raw noise bytes mixed in.
    random_start = bytes_fed;
    while (bytes_fed - random_start < RANDOM_ITEMS) begin
      write_reg(pcx_pkg::REG_IMAGE_WIDTH, pick_dim(1, 24));
      write_reg(pcx_pkg::REG_IMAGE_HEIGHT, pick_dim(1, 6));
      write_reg(pcx_pkg::REG_CLIP_WIDTH, pick_dim(0, 30));
      write_reg(pcx_pkg::REG_CLIP_HEIGHT, pick_dim(0, 8));
      phase_left = $urandom_range(25, 50);
      while (phase_left > 0) begin
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
          feed(8'($urandom_range(0, 255)), EXP_PREDICT, '0);
          phase_left--;
        end else if (pick < 11) begin
          case ($urandom_range(0, 9))
            0:       run_cnt = '0;
            1:       run_cnt = '1;
            2:       run_cnt = 6'($urandom_range(0, 63));
            default: run_cnt = 6'($urandom_range(1, 8));
          endcase
          feed(pcx_pkg::RUN_MARK | {2'b00, run_cnt}, EXP_PREDICT, '0);
          feed(8'($urandom_range(0, 255)), EXP_PREDICT, '0);
          phase_left = (phase_left > 2) ? phase_left - 2 : 0;
        end else begin
          feed(8'($urandom_range(0, 8'hBF)), EXP_PREDICT, '0);
          phase_left--;
        end
      end
    end

    // Drain, then give any stray word time to show up.
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_segs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
